/* design/pose_transform_velocity_estimator_macros.svh */
// Assertion helpers for the pose/velocity block
`ifndef POSE_TRANSFORM_VELOCITY_ESTIMATOR_MACROS_SVH
`define POSE_TRANSFORM_VELOCITY_ESTIMATOR_MACROS_SVH
`define PTVE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PTVE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* design/ptve_pkg.sv */
`default_nettype none
package ptve_pkg;
  localparam int unsigned NumLanes = 3;
  localparam int unsigned DivSteps = 53;
  localparam logic [1:0] StatFirst = 2'd0;
  localparam logic [1:0] StatValid = 2'd1;
  localparam logic [1:0] StatRestart = 2'd2;
  localparam logic OpPose = 1'b0;
  localparam logic OpPoint = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROT, ST_WORLD, ST_DIV, ST_OUT
  } state_t;

  // Q2.30 value rounded to Q2.15 and saturated to 18 bits
  function automatic logic signed [17:0] rot_round(input logic signed [35:0] q30);
    logic signed [21:0] r;
    r = 22'((q30 + 36'sd16384) >>> 15);
    if (r > 22'sd131071) return 18'sd131071;
    else if (r < -22'sd131072) return -18'sd131072;
    else return r[17:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    else if (v < -64'sd2147483648) return 32'h80000000;
    else return v[31:0];
  endfunction
endpackage
`default_nettype wire

/* design/ptve_lane.sv */
`default_nettype none
// One axis: world coordinate from a rotation row, then velocity by restoring division.
module ptve_lane import ptve_pkg::*; (
  input  wire logic clk,
  input  wire logic start_world,
  input  wire logic start_div,
  input  wire logic div_step,
  input  wire logic signed [17:0] r0,
  input  wire logic signed [17:0] r1,
  input  wire logic signed [17:0] r2,
  input  wire logic signed [18:0] b0,
  input  wire logic signed [18:0] b1,
  input  wire logic signed [18:0] b2,
  input  wire logic signed [31:0] trans,
  input  wire logic signed [31:0] prev_pos,
  input  wire logic [47:0] dt,
  output logic signed [31:0] world,
  output logic signed [31:0] vel
);
  logic signed [37:0] p0_r, p1_r, p2_r;
  logic signed [31:0] world_r;
  logic [52:0] num_r;        // 2*|d|*1e6 + dt, shifted out msb first
  logic [48:0] den_r;        // 2*dt, held for the whole divide
  logic [49:0] rem_r;
  logic [52:0] quo_r;
  logic neg_r;
  logic signed [39:0] acc;
  logic signed [32:0] dpos;
  logic [32:0] mag;
  logic [50:0] trial;
  logic [63:0] qsat;

  always_comb begin
    acc = 40'(p0_r) + 40'(p1_r) + 40'(p2_r);
    dpos = 33'(world_r) - 33'(prev_pos);
    mag = dpos[32] ? 33'(-dpos) : dpos;
    trial = {rem_r, num_r[52]} - {2'b0, den_r};
    qsat = 64'(quo_r);
  end

  always_ff @(posedge clk) begin
    p0_r <= 38'(r0 * b0);
    p1_r <= 38'(r1 * b1);
    p2_r <= 38'(r2 * b2);
    if (start_world)
      world_r <= sat32(64'((acc + 40'sd16384) >>> 15) + 64'(trans));
    if (start_div) begin
      neg_r <= dpos[32];
      num_r <= 53'({mag, 1'b0} * 53'd1000000) + 53'(dt);
      den_r <= {dt, 1'b0};
      rem_r <= '0;
      quo_r <= '0;
    end else if (div_step) begin
      num_r <= {num_r[51:0], 1'b0};
      if (!trial[50]) begin
        rem_r <= trial[49:0];
        quo_r <= {quo_r[51:0], 1'b1};
      end else begin
        rem_r <= {rem_r[48:0], num_r[52]};
        quo_r <= {quo_r[51:0], 1'b0};
      end
    end
  end

  assign world = world_r;
  assign vel = neg_r ? sat32(-$signed(qsat)) : sat32($signed(qsat));
endmodule
`default_nettype wire

/* design/pose_transform_velocity_estimator.sv */
// Pose item: after its transfer the rotation is built in ST_ROT and the input is then free
// again, no result. Depth item: the world position is formed in ST_WORLD, the divider is
// loaded and runs 53 restoring-divide steps in each lane in ST_DIV, and ST_OUT loads the
// result, makes it valid and frees the input. A waiting result only holds the next depth
// item at its output stage.
// Synchronous active-low reset: identity rotation, zero translation/history, first-sample pending.
`default_nettype none
module pose_transform_velocity_estimator import ptve_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic in_operation,
  input  wire logic signed [15:0] in_quat_x,
  input  wire logic signed [15:0] in_quat_y,
  input  wire logic signed [15:0] in_quat_z,
  input  wire logic signed [15:0] in_quat_w,
  input  wire logic signed [31:0] in_trans_x,
  input  wire logic signed [31:0] in_trans_y,
  input  wire logic signed [31:0] in_trans_z,
  input  wire logic signed [17:0] in_point_x,
  input  wire logic signed [17:0] in_point_y,
  input  wire logic signed [17:0] in_point_z,
  input  wire logic [47:0] in_stamp_us,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [31:0] out_world_x,
  output logic signed [31:0] out_world_y,
  output logic signed [31:0] out_world_z,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_vel_z,
  output logic [1:0] out_status
);
`include "pose_transform_velocity_estimator_macros.svh"
  state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic signed [17:0] rot_r [9];
  logic signed [31:0] trans_r [3];
  logic signed [31:0] prev_r [3];
  logic [47:0] prev_stamp_r, stamp_r;
  logic first_r;
  logic signed [15:0] qx_r, qy_r, qz_r, qw_r;
  logic signed [18:0] body_r [3];
  logic signed [32:0] sq_r [9];
  logic [1:0] stat_r;
  logic [1:0] os_r;
  logic out_valid_r;
  logic signed [31:0] ow_r [3];
  logic signed [31:0] ov_r [3];
  logic signed [31:0] world [NumLanes];
  logic signed [31:0] vel [NumLanes];
  logic accept, start_world, start_div, div_step, fin;

  assign in_ready = (state_r == ST_IDLE);
  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    case (state_r)
      ST_IDLE: if (accept) begin
        state_nxt = (in_operation == OpPose) ? ST_ROT : ST_WORLD;
        cnt_nxt = '0;
      end
      ST_ROT: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd1) state_nxt = ST_IDLE;
      end
      ST_WORLD: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd2) begin
          state_nxt = ST_DIV;
          cnt_nxt = '0;
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(DivSteps)) state_nxt = ST_OUT;
      end
      ST_OUT: if (!out_valid_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    start_world = (state_r == ST_WORLD) && (cnt_r == 6'd1);
    start_div = (state_r == ST_DIV) && (cnt_r == 6'd0);
    div_step = (state_r == ST_DIV) && (cnt_r != 6'd0);
    fin = (state_r == ST_OUT) && !out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      first_r <= 1'b1;
      prev_stamp_r <= '0;
      for (int i = 0; i < 9; i++) rot_r[i] <= (i % 4 == 0) ? 18'sd32768 : 18'sd0;
      for (int i = 0; i < 3; i++) begin
        trans_r[i] <= '0;
        prev_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (accept && in_operation == OpPose) begin
        trans_r[0] <= in_trans_x;
        trans_r[1] <= in_trans_y;
        trans_r[2] <= in_trans_z;
      end
      if (state_r == ST_ROT && cnt_r == 6'd1) begin
        rot_r[0] <= rot_round(36'sd1073741824 - 36'(sq_r[1]) - 36'(sq_r[2]));
        rot_r[1] <= rot_round(36'(sq_r[3]) - 36'(sq_r[4]));
        rot_r[2] <= rot_round(36'(sq_r[5]) + 36'(sq_r[6]));
        rot_r[3] <= rot_round(36'(sq_r[3]) + 36'(sq_r[4]));
        rot_r[4] <= rot_round(36'sd1073741824 - 36'(sq_r[0]) - 36'(sq_r[2]));
        rot_r[5] <= rot_round(36'(sq_r[7]) - 36'(sq_r[8]));
        rot_r[6] <= rot_round(36'(sq_r[5]) - 36'(sq_r[6]));
        rot_r[7] <= rot_round(36'(sq_r[7]) + 36'(sq_r[8]));
        rot_r[8] <= rot_round(36'sd1073741824 - 36'(sq_r[0]) - 36'(sq_r[1]));
      end
      if (state_r == ST_DIV && cnt_r == 6'd0) begin
        if (first_r) begin
          stat_r <= StatFirst;
          first_r <= 1'b0;
          prev_stamp_r <= stamp_r;
        end else if (stamp_r <= prev_stamp_r) begin
          stat_r <= StatRestart;
          first_r <= 1'b1;
        end else begin
          stat_r <= StatValid;
          prev_stamp_r <= stamp_r;
        end
      end
      if (fin) begin
        out_valid_r <= 1'b1;
        if (stat_r != StatRestart)
          for (int i = 0; i < 3; i++) prev_r[i] <= world[i];
      end
    end
  end

  // Payload registers; squares/products are doubled Q2.30 terms.
  always_ff @(posedge clk) begin
    if (accept) begin
      qx_r <= in_quat_x; qy_r <= in_quat_y; qz_r <= in_quat_z; qw_r <= in_quat_w;
      body_r[0] <= 19'(in_point_z);
      body_r[1] <= -19'(in_point_x);
      body_r[2] <= -19'(in_point_y);
      stamp_r <= in_stamp_us;
    end
    if (state_r == ST_ROT && cnt_r == 6'd0) begin
      sq_r[0] <= 33'(qx_r * qx_r) <<< 1;
      sq_r[1] <= 33'(qy_r * qy_r) <<< 1;
      sq_r[2] <= 33'(qz_r * qz_r) <<< 1;
      sq_r[3] <= 33'(qx_r * qy_r) <<< 1;
      sq_r[4] <= 33'(qz_r * qw_r) <<< 1;
      sq_r[5] <= 33'(qx_r * qz_r) <<< 1;
      sq_r[6] <= 33'(qy_r * qw_r) <<< 1;
      sq_r[7] <= 33'(qy_r * qz_r) <<< 1;
      sq_r[8] <= 33'(qx_r * qw_r) <<< 1;
    end
    if (fin) begin
      os_r <= stat_r;
      for (int i = 0; i < 3; i++) begin
        ow_r[i] <= world[i];
        ov_r[i] <= (stat_r == StatValid) ? vel[i] : 32'sd0;
      end
    end
  end

  genvar g;
  for (g = 0; g < NumLanes; g++) begin : g_lane
    ptve_lane u_lane (
      .clk(clk), .start_world(start_world), .start_div(start_div), .div_step(div_step),
      .r0(rot_r[3*g]), .r1(rot_r[3*g+1]), .r2(rot_r[3*g+2]),
      .b0(body_r[0]), .b1(body_r[1]), .b2(body_r[2]),
      .trans(trans_r[g]), .prev_pos(prev_r[g]),
      .dt(stamp_r - prev_stamp_r),
      .world(world[g]), .vel(vel[g])
    );
  end

  assign out_valid = out_valid_r;
  assign out_world_x = ow_r[0];
  assign out_world_y = ow_r[1];
  assign out_world_z = ow_r[2];
  assign out_vel_x = ov_r[0];
  assign out_vel_y = ov_r[1];
  assign out_vel_z = ov_r[2];
  assign out_status = os_r;

  `PTVE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `PTVE_ASSERT_NEXT(a_fin_valid, clk, rst_n, fin, out_valid_r)
  `PTVE_ASSERT_IMPL(a_restart_zero, clk, rst_n, out_valid && out_status == StatRestart,
    out_vel_x == 32'sd0 && out_vel_y == 32'sd0 && out_vel_z == 32'sd0)
endmodule
`default_nettype wire
